[hw/rtl/gap_buffer_text_store_defines.svh]
// Assertion macros shared by the gap buffer text store.
`ifndef GAP_BUFFER_TEXT_STORE_DEFINES_SVH
`define GAP_BUFFER_TEXT_STORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GBTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define GBTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/gbts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gbts_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int FIELD_W  = 10;
  localparam int CMP_W    = ((ADDR_W > FIELD_W) ? ADDR_W : FIELD_W) + 1;

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_BACKSPACE = 3'd1;
  localparam logic [2:0] OP_DELETE    = 3'd2;
  localparam logic [2:0] OP_MOVE      = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [7:0]         char_in;
    logic [FIELD_W-1:0] position;
  } req_t;

  typedef struct packed {
    logic [7:0]         char_out;
    logic [FIELD_W-1:0] text_length;
    logic [FIELD_W-1:0] cursor;
    logic [1:0]         status;
  } rsp_t;

endpackage

`default_nettype wire

[hw/rtl/gbts_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module gbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[hw/rtl/gap_buffer_text_store.sv]
// Insert, backspace, delete, unused codes and rejected requests go from acceptance straight
// to the done state; a read passes the read state first; a gap move copies byte by byte in
// the move state, paced by the single read and write port pair of the text memory.
// Throughput: one request at a time; the next is accepted once the current response
// is held in the output register. Reset clears the gap to the whole store, empties
// the output register and needs no clearing pass; text cells hold nothing until written.
`timescale 1ns / 1ps
`default_nettype none
`include "gap_buffer_text_store_defines.svh"

module gap_buffer_text_store (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire gbts_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output gbts_pkg::rsp_t     rsp
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_MOVE, S_DONE} state_t;

  state_t                         state;
  logic [gbts_pkg::ADDR_W-1:0]    gap_first;
  logic [gbts_pkg::ADDR_W-1:0]    gap_last;
  logic [gbts_pkg::ADDR_W-1:0]    target;
  logic                           move_left;
  logic                           wr_pend;
  logic [gbts_pkg::ADDR_W-1:0]    wr_addr_q;
  logic [7:0]                     res_char;
  logic [1:0]                     res_status;

  logic                           accept;
  logic [gbts_pkg::CMP_W-1:0]     pos_w;
  logic [gbts_pkg::CMP_W-1:0]     gf_w;
  logic [gbts_pkg::CMP_W-1:0]     gl_w;
  logic [gbts_pkg::CMP_W-1:0]     len_w;
  logic [gbts_pkg::CMP_W-1:0]     cell_w;
  logic [gbts_pkg::ADDR_W-1:0]    idle_addr;
  logic [gbts_pkg::ADDR_W-1:0]    move_src;
  logic                           ram_wr_en;
  logic [gbts_pkg::ADDR_W-1:0]    ram_wr_addr;
  logic [7:0]                     ram_wr_data;
  logic [gbts_pkg::ADDR_W-1:0]    ram_rd_addr;
  logic [7:0]                     ram_rd_data;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  assign pos_w  = gbts_pkg::CMP_W'(req.position);
  assign gf_w   = gbts_pkg::CMP_W'(gap_first);
  assign gl_w   = gbts_pkg::CMP_W'(gap_last);
  assign len_w  = gf_w + gbts_pkg::CMP_W'(gbts_pkg::CAPACITY - 1) - gl_w;
  assign cell_w = pos_w + gl_w - gf_w + gbts_pkg::CMP_W'(1);

  // Logical indices at or after the cursor are skewed past the gap.
  assign idle_addr = (pos_w < gf_w) ? pos_w[gbts_pkg::ADDR_W-1:0]
                                    : cell_w[gbts_pkg::ADDR_W-1:0];
  assign move_src  = move_left ? gap_first - gbts_pkg::ADDR_W'(1)
                               : gap_last + gbts_pkg::ADDR_W'(1);

  assign ram_rd_addr = (state == S_MOVE) ? move_src : idle_addr;
  assign ram_wr_en   = wr_pend ||
                       (accept && req.opcode == gbts_pkg::OP_INSERT && gap_first != gap_last);
  assign ram_wr_addr = wr_pend ? wr_addr_q : gap_first;
  assign ram_wr_data = wr_pend ? ram_rd_data : req.char_in;

  gbts_ram #(
    .WIDTH(8),
    .DEPTH(gbts_pkg::CAPACITY)
  ) u_text (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gap_first <= '0;
      gap_last  <= gbts_pkg::ADDR_W'(gbts_pkg::CAPACITY - 1);
      wr_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_char   <= 8'd0;
            res_status <= gbts_pkg::ST_OK;
            state      <= S_DONE;
            case (req.opcode)
              gbts_pkg::OP_INSERT: begin
                if (gap_first == gap_last) begin
                  res_status <= gbts_pkg::ST_FULL;
                end else begin
                  gap_first <= gap_first + gbts_pkg::ADDR_W'(1);
                end
              end
              gbts_pkg::OP_BACKSPACE: begin
                if (gap_first != '0) begin
                  gap_first <= gap_first - gbts_pkg::ADDR_W'(1);
                end else begin
                  res_status <= gbts_pkg::ST_EMPTY;
                end
              end
              gbts_pkg::OP_DELETE: begin
                if (gap_last != gbts_pkg::ADDR_W'(gbts_pkg::CAPACITY - 1)) begin
                  gap_last <= gap_last + gbts_pkg::ADDR_W'(1);
                end else begin
                  res_status <= gbts_pkg::ST_EMPTY;
                end
              end
              gbts_pkg::OP_MOVE: begin
                if (pos_w > len_w) begin
                  res_status <= gbts_pkg::ST_RANGE;
                end else if (pos_w != gf_w) begin
                  target    <= pos_w[gbts_pkg::ADDR_W-1:0];
                  move_left <= (pos_w < gf_w);
                  state     <= S_MOVE;
                end
              end
              gbts_pkg::OP_READ: begin
                if (pos_w >= len_w) begin
                  res_status <= gbts_pkg::ST_RANGE;
                end else begin
                  state <= S_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          res_char <= ram_rd_data;
          state    <= S_DONE;
        end
        S_MOVE: begin
          // Each cycle reads one byte across the gap and writes the byte read last cycle.
          if (gap_first != target) begin
            wr_pend <= 1'b1;
            if (move_left) begin
              gap_first <= gap_first - gbts_pkg::ADDR_W'(1);
              gap_last  <= gap_last - gbts_pkg::ADDR_W'(1);
              wr_addr_q <= gap_last;
            end else begin
              gap_first <= gap_first + gbts_pkg::ADDR_W'(1);
              gap_last  <= gap_last + gbts_pkg::ADDR_W'(1);
              wr_addr_q <= gap_first;
            end
          end else begin
            wr_pend <= 1'b0;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.char_out    <= res_char;
            rsp.text_length <= len_w[gbts_pkg::FIELD_W-1:0];
            rsp.cursor      <= gf_w[gbts_pkg::FIELD_W-1:0];
            rsp.status      <= res_status;
            rsp_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `GBTS_ASSERT_NOW(a_gap_not_empty, clk, rst, 1'b1, gap_first <= gap_last, "gap has no cell left")
  `GBTS_ASSERT_NOW(a_idle_no_write, clk, rst, state != S_MOVE, !wr_pend, "stray copy write")
  `GBTS_ASSERT_NEXT(a_move_keeps_len, clk, rst, state == S_MOVE, $stable(len_w), "length changed")

endmodule

`default_nettype wire

[bench/gap_buffer_text_store_tb.sv]
`timescale 1ns / 1ps

module gap_buffer_text_store_tb;
  import gbts_pkg::*;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_MID   = 3'd6;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam int         MAX_TEXT       = CAPACITY - 1;
  localparam int         FIELD_MAX      = (1 << FIELD_W) - 1;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  gap_buffer_text_store dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  logic [7:0] shadow_cells [CAPACITY];
  int         gap_lo;
  int         gap_hi;
  rsp_t       shadow_replies [$];

  bit idling_on;
  int rsp_hold_cycles;
  int mismatch_count;
  int requests_sent;
  int replies_seen;
  int status_tally [4];
  int peak_length;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("gap_buffer_text_store verification failed");
    $finish;
  end

  function automatic int text_len();
    return gap_lo + (CAPACITY - 1 - gap_hi);
  endfunction

  function automatic int near_cursor(int span);
    int target;
    target = gap_lo + $urandom_range(0, 2 * span) - span;
    if (target < 0) target = 0;
    if (target > text_len()) target = text_len();
    return target;
  endfunction

  task automatic edit_shadow_text(input req_t r, output rsp_t reply);
    int len;
    int pos;
    int slot;
    len   = text_len();
    pos   = r.position;
    reply = '0;
    reply.status = ST_OK;
    case (r.opcode)
      OP_INSERT: begin
        if (gap_lo >= gap_hi) begin
          reply.status = ST_FULL;
        end else begin
          shadow_cells[gap_lo] = r.char_in;
          gap_lo++;
        end
      end
      OP_BACKSPACE: begin
        if (gap_lo > 0) gap_lo--;
        else reply.status = ST_EMPTY;
      end
      OP_DELETE: begin
        if (gap_hi < CAPACITY - 1) gap_hi++;
        else reply.status = ST_EMPTY;
      end
      OP_MOVE: begin
        if (pos > len) begin
          reply.status = ST_RANGE;
        end else begin
          while (gap_lo > pos) begin
            gap_lo--;
            shadow_cells[gap_hi] = shadow_cells[gap_lo];
            gap_hi--;
          end
          while (gap_lo < pos) begin
            gap_hi++;
            shadow_cells[gap_lo] = shadow_cells[gap_hi];
            gap_lo++;
          end
        end
      end
      OP_READ: begin
        if (pos >= len) begin
          reply.status = ST_RANGE;
        end else if (pos < gap_lo) begin
          reply.char_out = shadow_cells[pos];
        end else begin
          slot = pos + (gap_hi - gap_lo) + 1;
          if (slot < CAPACITY) reply.char_out = shadow_cells[slot];
        end
      end
      default: begin
      end
    endcase
    reply.text_length = FIELD_W'(text_len());
    reply.cursor      = FIELD_W'(gap_lo);
    status_tally[reply.status]++;
    if (text_len() > peak_length) peak_length = text_len();
  endtask

  task automatic send_request(input logic [2:0] op, input logic [7:0] ch, input int pos);
    req_t item;
    rsp_t reply;
    item.opcode   = op;
    item.char_in  = ch;
    item.position = FIELD_W'(pos);
    if (idling_on && $urandom_range(99) < 9) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!(req_valid && req_ready));
    edit_shadow_text(item, reply);
    shadow_replies.push_back(reply);
    requests_sent++;
  endtask

  function automatic req_t pick_edit();
    req_t r;
    int   roll;
    int   len;
    len        = text_len();
    roll       = $urandom_range(99);
    r.char_in  = 8'($urandom_range(255));
    r.position = FIELD_W'($urandom_range(FIELD_MAX));
    if (roll < 30) begin
      r.opcode = OP_INSERT;
    end else if (roll < 42) begin
      r.opcode = OP_BACKSPACE;
    end else if (roll < 54) begin
      r.opcode = OP_DELETE;
    end else if (roll < 72) begin
      r.opcode = OP_MOVE;
      roll = $urandom_range(99);
      if (roll < 70) r.position = FIELD_W'(near_cursor(12));
      else if (roll < 90 || len >= FIELD_MAX) r.position = FIELD_W'($urandom_range(len));
      else r.position = FIELD_W'($urandom_range(FIELD_MAX, len + 1));
    end else if (roll < 95) begin
      r.opcode = OP_READ;
      if (len > 0 && $urandom_range(99) < 85) r.position = FIELD_W'($urandom_range(len - 1));
    end else begin
      r.opcode = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    end
    return r;
  endfunction

  task automatic send_random_edit();
    req_t r;
    r = pick_edit();
    send_request(r.opcode, r.char_in, r.position);
  endtask

  task automatic drain_replies();
    req_valid <= 1'b0;
    while (shadow_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic check_reply(input rsp_t got);
    rsp_t want;
    replies_seen++;
    if (shadow_replies.size() == 0) begin
      $error("response arrived with no request outstanding");
      mismatch_count++;
    end else begin
      want = shadow_replies.pop_front();
      if (got.char_out !== want.char_out) begin
        $error("char_out: expected %0d, got %0d", want.char_out, got.char_out);
        mismatch_count++;
      end
      if (got.text_length !== want.text_length) begin
        $error("text_length: expected %0d, got %0d", want.text_length, got.text_length);
        mismatch_count++;
      end
      if (got.cursor !== want.cursor) begin
        $error("cursor: expected %0d, got %0d", want.cursor, got.cursor);
        mismatch_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatch_count++;
      end
    end
  endtask

  initial begin
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_valid === 1'b1 && rsp_ready) check_reply(rsp);
      if (rsp_hold_cycles > 0) begin
        rsp_hold_cycles--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= !(idling_on && $urandom_range(99) < 9);
      end
    end
  end

  task automatic test_directed_edits();
    send_request(OP_BACKSPACE, 8'h00, 0);
    send_request(OP_DELETE, 8'hFF, FIELD_MAX);
    send_request(OP_READ, 8'h00, 0);
    send_request(OP_MOVE, 8'h00, 0);
    send_request(OP_MOVE, 8'h00, 1);
    send_request(OP_SPARE_FIRST, 8'hFF, FIELD_MAX);
    send_request(OP_SPARE_LAST, 8'h00, 0);
    send_request(OP_INSERT, 8'h00, FIELD_MAX);
    send_request(OP_INSERT, 8'hFF, 0);
    send_request(OP_INSERT, 8'hA5, 512);
    send_request(OP_INSERT, 8'h5A, 341);
    send_request(OP_READ, 8'h00, 0);
    send_request(OP_READ, 8'h00, 3);
    send_request(OP_READ, 8'h00, 4);
    send_request(OP_READ, 8'h00, FIELD_MAX);
    send_request(OP_MOVE, 8'h00, 0);
    send_request(OP_READ, 8'h00, 0);
    send_request(OP_READ, 8'h00, 3);
    send_request(OP_MOVE, 8'h00, 2);
    send_request(OP_MOVE, 8'h00, 2);
    send_request(OP_BACKSPACE, 8'h00, 0);
    send_request(OP_DELETE, 8'h00, 0);
    send_request(OP_MOVE, 8'h00, 3);
    send_request(OP_MOVE, 8'h00, 2);
    send_request(OP_DELETE, 8'h00, 0);
    send_request(OP_SPARE_MID, 8'h3C, 682);
    drain_replies();
  endtask

  task automatic test_fill_to_capacity();
    int count;
    int roll;
    count     = 0;
    idling_on = 1'b0;
    while (text_len() < MAX_TEXT) begin
      if (count == 200) idling_on = 1'b1;
      roll = $urandom_range(99);
      if (roll < 97) send_request(OP_INSERT, 8'($urandom_range(255)), $urandom_range(FIELD_MAX));
      else if (roll < 99) send_request(OP_READ, 8'h00, $urandom_range(text_len() - 1));
      else send_request(OP_MOVE, 8'h00, near_cursor(16));
      count++;
    end
    send_request(OP_INSERT, 8'hFF, 0);
    send_request(OP_INSERT, 8'h00, FIELD_MAX);
    send_request(OP_READ, 8'h00, 0);
    send_request(OP_READ, 8'h00, MAX_TEXT - 1);
    send_request(OP_READ, 8'h00, FIELD_MAX);
    send_request(OP_MOVE, 8'h00, 0);
    send_request(OP_INSERT, 8'h77, 0);
    send_request(OP_MOVE, 8'h00, FIELD_MAX);
    send_request(OP_DELETE, 8'h00, 0);
    send_request(OP_BACKSPACE, 8'h00, 0);
    send_request(OP_INSERT, 8'h81, 0);
    send_request(OP_INSERT, 8'h18, 0);
    drain_replies();
  endtask

  task automatic test_random_edits(input int count);
    repeat (count) send_random_edit();
    drain_replies();
  endtask

  task automatic test_response_backpressure();
    rsp_hold_cycles = 300;
    repeat (16) send_random_edit();
    drain_replies();
  endtask

  initial begin
    rst             <= 1'b1;
    req_valid       <= 1'b0;
    req             <= '0;
    idling_on       = 1'b1;
    rsp_hold_cycles = 0;
    mismatch_count  = 0;
    requests_sent   = 0;
    replies_seen    = 0;
    peak_length     = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    gap_lo          = 0;
    gap_hi          = CAPACITY - 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edits();
    test_fill_to_capacity();
    test_random_edits(30);
    test_response_backpressure();

    $display("%0d requests, %0d responses; peak text length %0d of %0d.",
             requests_sent, replies_seen, peak_length, MAX_TEXT);
    $display("Outcomes: %0d ok, %0d full, %0d nothing to remove, %0d out of range.",
             status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_EMPTY],
             status_tally[ST_RANGE]);
    if (mismatch_count == 0) begin
      $display("gap_buffer_text_store verification clean");
    end else begin
      $display("gap_buffer_text_store verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/gbts_pkg.sv
hw/rtl/gbts_ram.sv
hw/rtl/gap_buffer_text_store.sv
bench/gap_buffer_text_store_tb.sv
